### rtl/cdirf_pkg.sv
// ----------------------------------------------------------------------------
// cdirf_pkg
// Shared types and constants of the CD interface register file: access
// beats, result beats, slot codes, field masks and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package cdirf_pkg;

    localparam int FIFO_DEPTH = 4096;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // Access kinds.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;

    localparam logic SIDE_HOST = 1'b0;
    localparam logic SIDE_CTRL = 1'b1;

    // Host slots.
    localparam logic [3:0] HOST_SLOT_DATA  = 4'd0;
    localparam logic [3:0] HOST_SLOT_HREQ  = 4'd2;
    localparam logic [3:0] HOST_SLOT_HMASK = 4'd3;
    localparam logic [3:0] HOST_SLOT_CR1   = 4'd6;
    localparam logic [3:0] HOST_SLOT_CR4   = 4'd9;

    // Controller slots.
    localparam logic [3:0] CTRL_SLOT_DATA  = 4'd0;
    localparam logic [3:0] CTRL_SLOT_XFER  = 4'd1;
    localparam logic [3:0] CTRL_SLOT_LREQ  = 4'd2;
    localparam logic [3:0] CTRL_SLOT_HREQ  = 4'd3;
    localparam logic [3:0] CTRL_SLOT_LMASK = 4'd4;
    localparam logic [3:0] CTRL_SLOT_HMASK = 4'd5;
    localparam logic [3:0] CTRL_SLOT_MISC0 = 4'd6;
    localparam logic [3:0] CTRL_SLOT_MISC1 = 4'd7;
    localparam logic [3:0] CTRL_SLOT_CMD0  = 4'd8;
    localparam logic [3:0] CTRL_SLOT_CMD3  = 4'd11;
    localparam logic [3:0] CTRL_SLOT_MISC2 = 4'd12;
    localparam logic [3:0] CTRL_SLOT_MISC3 = 4'd13;
    localparam logic [3:0] CTRL_SLOT_MISC4 = 4'd14;
    localparam logic [3:0] CTRL_SLOT_HOST  = 4'd15;

    // Transfer control bits.
    localparam int TC_DIR   = 0;
    localparam int TC_CLEAR = 1;
    localparam int TC_EN    = 2;

    localparam logic [15:0] HIGH_SECTOR_BIT = 16'h0010;
    localparam logic [6:0]  HIGH_MASK_BITS  = 7'h70;
    localparam logic [7:0]  MISC3_BITS      = 8'hD7;

    typedef struct packed {
        logic        side;
        logic [1:0]  mode;
        logic [3:0]  reg_index;
        logic [15:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_low_line;
        logic        irq_high_line;
        logic        host_irq_line;
        logic        dma_request;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

### rtl/cdirf_ctrl.sv
// ----------------------------------------------------------------------------
// cdirf_ctrl
// Controller: takes an access beat, lets the datapath execute it once the
// result register is free, and tracks the result beat on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module cdirf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output cdirf_pkg::dp_cmd_t     cmd
);

    cdirf_pkg::state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdirf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        in_stall       = 1'b1;
        case (state_reg)
            cdirf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = cdirf_pkg::ST_EXEC;
                end
            end
            cdirf_pkg::ST_EXEC:
            begin
                // The result register must be empty or emptying this cycle.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cdirf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdirf_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == cdirf_pkg::ST_EXEC))
        else $error("accepted beat did not enter execution");
    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("executed beat produced no result beat");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

### rtl/cdirf_datapath.sv
// ----------------------------------------------------------------------------
// cdirf_datapath
// Register file, word FIFO with its memory, and the result register. An
// access beat is latched on capture and applied to the state on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module cdirf_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cdirf_pkg::dp_cmd_t   cmd,
    input  wire cdirf_pkg::in_item_t  in_data,
    output cdirf_pkg::out_item_t      out_data
);

    localparam int AW = cdirf_pkg::FIFO_AW;
    localparam int FW = cdirf_pkg::FILL_W;

    cdirf_pkg::in_item_t  item_reg;
    cdirf_pkg::out_item_t res_reg, res_next;

    logic [3:0]  tc_reg, tc_next;
    logic [1:0]  lreq_reg, lreq_next;
    logic [15:0] hreq_reg, hreq_next;
    logic [1:0]  lmask_reg, lmask_next;
    logic [6:0]  hmask_reg, hmask_next;
    logic [1:0]  misc0_reg, misc0_next;
    logic [15:0] misc1_reg, misc1_next;
    logic [5:0]  misc2_reg, misc2_next;
    logic [7:0]  misc3_reg, misc3_next;
    logic [7:0]  misc4_reg, misc4_next;
    logic [13:0] host_req_reg, host_req_next;
    logic [15:0] host_mask_reg, host_mask_next;
    logic [15:0] cmd_reg [4];
    logic [15:0] cmd_next [4];
    logic [15:0] resp_reg [4];
    logic [15:0] resp_next [4];
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [15:0] fifo_mem [cdirf_pkg::FIFO_DEPTH];
    logic [15:0] fifo_rdata_reg;

    logic        wr;
    logic        push_req, pop_req, clear_req;
    logic        push_do, pop_do;
    logic        buf_full, buf_empty;
    logic [15:0] pop_data;
    logic [15:0] rd_val;
    logic [1:0]  host_k;
    logic        dreq;

    assign wr        = (item_reg.mode == cdirf_pkg::MODE_WRITE);
    assign buf_empty = (fill_reg == '0);
    assign buf_full  = (fill_reg >= FW'(cdirf_pkg::FIFO_DEPTH));
    assign pop_data  = buf_empty ? 16'h0000 : fifo_rdata_reg;
    assign host_k    = 2'(item_reg.reg_index - cdirf_pkg::HOST_SLOT_CR1);

    always_comb
    begin
        tc_next        = tc_reg;
        lreq_next      = lreq_reg;
        hreq_next      = hreq_reg;
        lmask_next     = lmask_reg;
        hmask_next     = hmask_reg;
        misc0_next     = misc0_reg;
        misc1_next     = misc1_reg;
        misc2_next     = misc2_reg;
        misc3_next     = misc3_reg;
        misc4_next     = misc4_reg;
        host_req_next  = host_req_reg;
        host_mask_next = host_mask_reg;
        cmd_next       = cmd_reg;
        resp_next      = resp_reg;
        push_req       = 1'b0;
        pop_req        = 1'b0;
        clear_req      = 1'b0;
        rd_val         = 16'h0000;

        if (item_reg.mode == cdirf_pkg::MODE_EVENT)
        begin
            hreq_next = hreq_reg | cdirf_pkg::HIGH_SECTOR_BIT;
        end
        else if (item_reg.mode == cdirf_pkg::MODE_READ || wr)
        begin
            if (item_reg.side == cdirf_pkg::SIDE_HOST)
            begin
                case (item_reg.reg_index) inside
                    cdirf_pkg::HOST_SLOT_DATA:
                    begin
                        if (wr)
                        begin
                            push_req = tc_reg[cdirf_pkg::TC_DIR];
                        end
                        else if (!tc_reg[cdirf_pkg::TC_DIR])
                        begin
                            pop_req = 1'b1;
                            rd_val  = pop_data;
                        end
                    end
                    cdirf_pkg::HOST_SLOT_HREQ:
                    begin
                        if (wr)
                            host_req_next = host_req_reg & item_reg.write_data[13:0];
                        else
                            rd_val = 16'(host_req_reg);
                    end
                    cdirf_pkg::HOST_SLOT_HMASK:
                    begin
                        if (wr)
                            host_mask_next = item_reg.write_data;
                        else
                            rd_val = host_mask_reg;
                    end
                    [cdirf_pkg::HOST_SLOT_CR1:cdirf_pkg::HOST_SLOT_CR4]:
                    begin
                        // Touching the last command slot signals the controller.
                        if (wr)
                        begin
                            cmd_next[host_k] = item_reg.write_data;
                            if (item_reg.reg_index == cdirf_pkg::HOST_SLOT_CR4)
                                lreq_next = lreq_reg | 2'b01;
                        end
                        else
                        begin
                            rd_val = resp_reg[host_k];
                            if (item_reg.reg_index == cdirf_pkg::HOST_SLOT_CR4)
                                lreq_next = lreq_reg | 2'b10;
                        end
                    end
                    default:
                    begin
                        rd_val = 16'h0000;
                    end
                endcase
            end
            else if (wr)
            begin
                case (item_reg.reg_index) inside
                    cdirf_pkg::CTRL_SLOT_DATA:
                    begin
                        push_req = 1'b1;
                        if (tc_reg[cdirf_pkg::TC_EN] && tc_reg[cdirf_pkg::TC_DIR])
                            tc_next[cdirf_pkg::TC_EN] = 1'b0;
                    end
                    cdirf_pkg::CTRL_SLOT_XFER:
                    begin
                        tc_next   = item_reg.write_data[3:0];
                        clear_req = item_reg.write_data[cdirf_pkg::TC_CLEAR];
                    end
                    cdirf_pkg::CTRL_SLOT_LREQ:  lreq_next  = item_reg.write_data[1:0];
                    cdirf_pkg::CTRL_SLOT_HREQ:  hreq_next  = hreq_reg & item_reg.write_data;
                    cdirf_pkg::CTRL_SLOT_LMASK: lmask_next = item_reg.write_data[1:0];
                    cdirf_pkg::CTRL_SLOT_HMASK:
                        hmask_next = item_reg.write_data[6:0] & cdirf_pkg::HIGH_MASK_BITS;
                    cdirf_pkg::CTRL_SLOT_MISC0: misc0_next = item_reg.write_data[1:0];
                    cdirf_pkg::CTRL_SLOT_MISC1: misc1_next = item_reg.write_data;
                    [cdirf_pkg::CTRL_SLOT_CMD0:cdirf_pkg::CTRL_SLOT_CMD3]:
                        resp_next[item_reg.reg_index[1:0]] = item_reg.write_data;
                    cdirf_pkg::CTRL_SLOT_MISC2: misc2_next = item_reg.write_data[5:0];
                    cdirf_pkg::CTRL_SLOT_MISC3:
                        misc3_next = item_reg.write_data[7:0] & cdirf_pkg::MISC3_BITS;
                    cdirf_pkg::CTRL_SLOT_MISC4: misc4_next = item_reg.write_data[7:0];
                    default:
                        host_req_next = host_req_reg | item_reg.write_data[13:0];
                endcase
            end
            else
            begin
                case (item_reg.reg_index) inside
                    cdirf_pkg::CTRL_SLOT_DATA:
                    begin
                        // Draining the last inbound word re-arms the transfer.
                        if (!tc_reg[cdirf_pkg::TC_EN] && tc_reg[cdirf_pkg::TC_DIR]
                            && fill_reg == FW'(1))
                            tc_next[cdirf_pkg::TC_EN] = 1'b1;
                        pop_req = 1'b1;
                        rd_val  = pop_data;
                    end
                    cdirf_pkg::CTRL_SLOT_XFER:  rd_val = 16'(tc_reg);
                    cdirf_pkg::CTRL_SLOT_LREQ:  rd_val = 16'(lreq_reg);
                    cdirf_pkg::CTRL_SLOT_HREQ:  rd_val = hreq_reg;
                    cdirf_pkg::CTRL_SLOT_LMASK: rd_val = 16'(lmask_reg);
                    cdirf_pkg::CTRL_SLOT_HMASK: rd_val = 16'(hmask_reg);
                    cdirf_pkg::CTRL_SLOT_MISC0: rd_val = 16'(misc0_reg);
                    cdirf_pkg::CTRL_SLOT_MISC1: rd_val = misc1_reg;
                    [cdirf_pkg::CTRL_SLOT_CMD0:cdirf_pkg::CTRL_SLOT_CMD3]:
                        rd_val = cmd_reg[item_reg.reg_index[1:0]];
                    cdirf_pkg::CTRL_SLOT_MISC2: rd_val = 16'(misc2_reg);
                    cdirf_pkg::CTRL_SLOT_MISC3: rd_val = 16'(misc3_reg);
                    cdirf_pkg::CTRL_SLOT_MISC4: rd_val = 16'(misc4_reg);
                    default:                    rd_val = 16'(host_req_reg);
                endcase
            end
        end
    end

    // FIFO pointer and fill update; at most one of push, pop and clear per beat.
    assign push_do = push_req && !buf_full;
    assign pop_do  = pop_req && !buf_empty;

    always_comb
    begin
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        fill_next = fill_reg;
        if (clear_req)
        begin
            rptr_next = '0;
            wptr_next = '0;
            fill_next = '0;
        end
        else if (push_do)
        begin
            wptr_next = (wptr_reg == AW'(cdirf_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            fill_next = fill_reg + FW'(1);
        end
        else if (pop_do)
        begin
            rptr_next = (rptr_reg == AW'(cdirf_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
    end

    always_comb
    begin
        if (tc_next[cdirf_pkg::TC_DIR])
            dreq = tc_next[cdirf_pkg::TC_EN] && (fill_next != '0);
        else
            dreq = tc_next[cdirf_pkg::TC_EN] && (fill_next < FW'(cdirf_pkg::FIFO_DEPTH));
        res_next.read_data     = wr ? 16'h0000 : rd_val;
        res_next.irq_low_line  = |(lreq_next & lmask_next);
        res_next.irq_high_line = |(hreq_next[6:0] & hmask_next);
        res_next.host_irq_line = |(host_req_next & host_mask_next[13:0]);
        res_next.dma_request   = dreq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg        <= '0;
            lreq_reg      <= '0;
            hreq_reg      <= '0;
            lmask_reg     <= '0;
            hmask_reg     <= '0;
            misc0_reg     <= '0;
            misc1_reg     <= '0;
            misc2_reg     <= '0;
            misc3_reg     <= '0;
            misc4_reg     <= '0;
            host_req_reg  <= '0;
            host_mask_reg <= '0;
            cmd_reg       <= '{default: '0};
            resp_reg      <= '{default: '0};
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            fill_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            tc_reg        <= tc_next;
            lreq_reg      <= lreq_next;
            hreq_reg      <= hreq_next;
            lmask_reg     <= lmask_next;
            hmask_reg     <= hmask_next;
            misc0_reg     <= misc0_next;
            misc1_reg     <= misc1_next;
            misc2_reg     <= misc2_next;
            misc3_reg     <= misc3_next;
            misc4_reg     <= misc4_next;
            host_req_reg  <= host_req_next;
            host_mask_reg <= host_mask_next;
            cmd_reg       <= cmd_next;
            resp_reg      <= resp_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.commit)
            res_reg <= res_next;
    end

    // The head word is fetched while the beat is latched, so it is ready when
    // the beat is executed.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push_do)
            fifo_mem[wptr_reg] <= item_reg.write_data;
        if (cmd.capture)
            fifo_rdata_reg <= fifo_mem[rptr_reg];
    end

    assign out_data = res_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(cdirf_pkg::FIFO_DEPTH))
        else $error("FIFO fill count beyond depth");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (rptr_reg == wptr_reg))
        else $error("empty FIFO with pointers apart");
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(fill_reg) && $stable(tc_reg))
        else $error("state changed without an executed beat");
`endif

endmodule

`default_nettype wire

### rtl/cd_interface_register_file_unit.sv
// ----------------------------------------------------------------------------
// cd_interface_register_file_unit
// Interface register file between a host bus and a drive controller CPU,
// with command/response words, interrupt request and mask words, and a
// directional word FIFO.
//
//   Channel   Direction  Handshake            Beat
//   in        to block   in_valid/in_stall    in_item_t: side, mode, slot, data
//   out       from block out_valid/out_stall  out_item_t: read data, four lines
//
// Each access is first latched, with the FIFO head word fetched from
// memory, and then executed against the registers.
// A new access is taken while the previous result still waits at the output.
// Execution waits while a finished result is stalled at the output.
// Reset clears the register file and FIFO pointers at once; the FIFO memory
// itself is not cleared, since only pushed words are ever popped.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_interface_register_file_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire cdirf_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output cdirf_pkg::out_item_t      out_data
);

    cdirf_pkg::dp_cmd_t cmd;

    cdirf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cdirf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CD interface register file. Host and controller
// accesses are sent one beat at a time, a predictor of the register file
// computes each result beat, and the results coming out are compared field
// by field in order. Directed tests cover the interrupt lines, the
// command/response words, the FIFO direction, re-arm, clear and empty
// cases, and unmapped slots. Random tests mix command exchanges, transfer
// bursts and single accesses, with or without random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdirf_pkg::*;

    // Access kind with no effect and host slots with nothing behind them.
    localparam logic [1:0] MODE_NONE           = 2'd3;
    localparam logic [3:0] HOST_SLOT_UNMAPPED  = 4'd1;
    localparam logic [3:0] HOST_SLOT_TOP       = 4'd15;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    cd_interface_register_file_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Register file image kept by the predictor.
    logic [3:0]  xfer_ctl;
    logic [1:0]  low_req;
    logic [1:0]  low_msk;
    logic [15:0] high_req;
    logic [6:0]  high_msk;
    logic [15:0] misc_reg [5];
    logic [13:0] host_req;
    logic [15:0] host_msk;
    logic [15:0] cmd_word [4];
    logic [15:0] rsp_word [4];
    logic [15:0] fifo_mem [FIFO_DEPTH];
    int          fifo_head;
    int          fifo_tail;
    int          fifo_count;

    out_item_t   pending_results[$];
    out_item_t   oldest_expected;
    int          error_count;
    int          beats_sent;

    // Idling controls shared between the tests, the access sender and the stall process.
    int          in_gap_pct;
    int          out_stall_pct;
    int          out_hold_cycles;
    int          out_stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 95)
            return $urandom_range(10, 4);
        return $urandom_range(40, 11);
    endfunction

    function automatic void model_push(logic [15:0] d);
        if (fifo_count >= FIFO_DEPTH)
            return;
        fifo_mem[fifo_tail] = d;
        fifo_tail = (fifo_tail + 1) % FIFO_DEPTH;
        fifo_count++;
    endfunction

    function automatic logic [15:0] model_pop();
        logic [15:0] v;
        if (fifo_count == 0)
            return 16'h0000;
        v = fifo_mem[fifo_head];
        fifo_head = (fifo_head + 1) % FIFO_DEPTH;
        fifo_count--;
        return v;
    endfunction

    function automatic void clear_register_file();
        xfer_ctl = '0;
        low_req = '0;
        low_msk = '0;
        high_req = '0;
        high_msk = '0;
        host_req = '0;
        host_msk = '0;
        for (int i = 0; i < 5; i++)
            misc_reg[i] = '0;
        for (int i = 0; i < 4; i++)
        begin
            cmd_word[i] = '0;
            rsp_word[i] = '0;
        end
        fifo_head = 0;
        fifo_tail = 0;
        fifo_count = 0;
    endfunction

    function automatic logic [15:0] host_side(logic wr, logic [3:0] slot, logic [15:0] d);
        int k;
        k = int'(slot) - int'(HOST_SLOT_CR1);
        if (slot == HOST_SLOT_DATA)
        begin
            if (wr)
            begin
                if (xfer_ctl[TC_DIR])
                    model_push(d);
                return 16'h0000;
            end
            return xfer_ctl[TC_DIR] ? 16'h0000 : model_pop();
        end
        if (slot == HOST_SLOT_HREQ)
        begin
            if (wr)
            begin
                host_req &= d[13:0];
                return 16'h0000;
            end
            return {2'b00, host_req};
        end
        if (slot == HOST_SLOT_HMASK)
        begin
            if (wr)
            begin
                host_msk = d;
                return 16'h0000;
            end
            return host_msk;
        end
        if (slot >= HOST_SLOT_CR1 && slot <= HOST_SLOT_CR4)
        begin
            if (wr)
            begin
                cmd_word[k] = d;
                if (slot == HOST_SLOT_CR4)
                    low_req[0] = 1'b1;
                return 16'h0000;
            end
            if (slot == HOST_SLOT_CR4)
                low_req[1] = 1'b1;
            return rsp_word[k];
        end
        return 16'h0000;
    endfunction

    function automatic logic [15:0] ctrl_read(logic [3:0] slot);
        case (slot)
            CTRL_SLOT_DATA:
            begin
                // The last word of a host-to-controller transfer re-arms the enable.
                if (!xfer_ctl[TC_EN] && xfer_ctl[TC_DIR] && fifo_count == 1)
                    xfer_ctl[TC_EN] = 1'b1;
                return model_pop();
            end
            CTRL_SLOT_XFER:  return {12'h000, xfer_ctl};
            CTRL_SLOT_LREQ:  return {14'h0000, low_req};
            CTRL_SLOT_HREQ:  return high_req;
            CTRL_SLOT_LMASK: return {14'h0000, low_msk};
            CTRL_SLOT_HMASK: return {9'h000, high_msk};
            CTRL_SLOT_MISC0: return misc_reg[0];
            CTRL_SLOT_MISC1: return misc_reg[1];
            CTRL_SLOT_MISC2: return misc_reg[2];
            CTRL_SLOT_MISC3: return misc_reg[3];
            CTRL_SLOT_MISC4: return misc_reg[4];
            CTRL_SLOT_HOST:  return {2'b00, host_req};
            default:         return cmd_word[slot - CTRL_SLOT_CMD0];
        endcase
    endfunction

    function automatic void ctrl_write(logic [3:0] slot, logic [15:0] d);
        case (slot)
            CTRL_SLOT_DATA:
            begin
                model_push(d);
                if (xfer_ctl[TC_EN] && xfer_ctl[TC_DIR])
                    xfer_ctl[TC_EN] = 1'b0;
            end
            CTRL_SLOT_XFER:
            begin
                xfer_ctl = d[3:0];
                if (xfer_ctl[TC_CLEAR])
                begin
                    fifo_head = 0;
                    fifo_tail = 0;
                    fifo_count = 0;
                end
            end
            CTRL_SLOT_LREQ:  low_req = d[1:0];
            CTRL_SLOT_HREQ:  high_req &= d;
            CTRL_SLOT_LMASK: low_msk = d[1:0];
            CTRL_SLOT_HMASK: high_msk = d[6:0] & HIGH_MASK_BITS;
            CTRL_SLOT_MISC0: misc_reg[0] = d & 16'h0003;
            CTRL_SLOT_MISC1: misc_reg[1] = d;
            CTRL_SLOT_MISC2: misc_reg[2] = d & 16'h003f;
            CTRL_SLOT_MISC3: misc_reg[3] = {8'h00, d[7:0] & MISC3_BITS};
            CTRL_SLOT_MISC4: misc_reg[4] = d & 16'h00ff;
            CTRL_SLOT_HOST:  host_req |= d[13:0];
            default:         rsp_word[slot - CTRL_SLOT_CMD0] = d;
        endcase
    endfunction

    // Applies one access to the register file image and returns its result beat.
    function automatic out_item_t regfile_access(in_item_t a);
        out_item_t r;
        logic      wr;
        logic [15:0] rd;
        rd = 16'h0000;
        wr = (a.mode == MODE_WRITE);
        if (a.mode == MODE_EVENT)
            high_req |= HIGH_SECTOR_BIT;
        else if (a.mode == MODE_READ || a.mode == MODE_WRITE)
        begin
            if (a.side == SIDE_HOST)
                rd = host_side(wr, a.reg_index, a.write_data);
            else if (wr)
                ctrl_write(a.reg_index, a.write_data);
            else
                rd = ctrl_read(a.reg_index);
        end
        r.read_data     = rd;
        r.irq_low_line  = |(low_req & low_msk);
        r.irq_high_line = |(high_req & {9'h000, high_msk});
        r.host_irq_line = |({2'b00, host_req} & host_msk);
        r.dma_request   = xfer_ctl[TC_EN] &&
                          (xfer_ctl[TC_DIR] ? fifo_count != 0 : fifo_count < FIFO_DEPTH);
        return r;
    endfunction

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Result checker: every accepted result beat is matched to the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                oldest_expected = pending_results.pop_front();
                check_field("read_data", oldest_expected.read_data, out_data.read_data);
                check_field("irq_low_line", oldest_expected.irq_low_line,
                            out_data.irq_low_line);
                check_field("irq_high_line", oldest_expected.irq_high_line,
                            out_data.irq_high_line);
                check_field("host_irq_line", oldest_expected.host_irq_line,
                            out_data.host_irq_line);
                check_field("dma_request", oldest_expected.dma_request,
                            out_data.dma_request);
            end
        end
    end

    // Result side stalls: random stretches, plus a long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_stall_left == 0 && out_stall_pct > 0 && $urandom_range(99) < out_stall_pct)
                out_stall_left = pick_gap();
            if (out_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                out_hold_cycles--;
            end
            else if (out_stall_left > 0)
            begin
                out_stall <= 1'b1;
                out_stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Valid is left high after a beat is taken so that back-to-back beats need
    // no second assignment in the same step; a gap or a drain lowers it.
    task automatic send_access(in_item_t a);
        int gap;
        gap = (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= a;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(regfile_access(a));
        if (a.mode != MODE_NONE)
            beats_sent++;
    endtask

    task automatic access(logic side, logic [1:0] mode, logic [3:0] slot, logic [15:0] d);
        in_item_t a;
        a.side = side;
        a.mode = mode;
        a.reg_index = slot;
        a.write_data = d;
        send_access(a);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_interrupt_lines();
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_LMASK, 16'hffff);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_HMASK, 16'hffff);
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_HMASK, 16'hffff);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_HMASK, 16'h0000);
        access(SIDE_CTRL, MODE_EVENT, CTRL_SLOT_HOST, 16'hffff);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_HREQ, 16'h0000);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_HREQ, 16'h0000);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_HOST, 16'hffff);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_HREQ, 16'h0000);
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_HREQ, 16'h0000);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_LREQ, 16'hffff);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_LREQ, 16'h0000);
    endtask

    task automatic test_command_response();
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_CR4, 16'hffff);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_CMD3, 16'h0000);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_CMD3, 16'h8001);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_CR4, 16'h0000);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_LREQ, 16'h0000);
    endtask

    task automatic test_fifo_corners();
        logic [15:0] ctl;
        // Host-to-controller with the enable off: the last word re-arms it.
        ctl = '0;
        ctl[TC_DIR] = 1'b1;
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_XFER, ctl);
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_DATA, 16'hffff);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_DATA, 16'h0000);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_DATA, 16'h0000);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_DATA, 16'h0000);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_DATA, 16'h1234);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_XFER, 16'h0000);
        // All control bits at once, which also empties the FIFO.
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_XFER, 16'hffff);
        access(SIDE_CTRL, MODE_READ, CTRL_SLOT_DATA, 16'h0000);
        ctl = '0;
        ctl[TC_EN] = 1'b1;
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_XFER, ctl);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_DATA, 16'h0000);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_DATA, 16'h0000);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_DATA, 16'h0000);
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_DATA, 16'h5555);
    endtask

    task automatic test_unmapped_slots();
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_UNMAPPED, 16'hffff);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_UNMAPPED, 16'h0000);
        access(SIDE_HOST, MODE_WRITE, HOST_SLOT_TOP, 16'hffff);
        access(SIDE_HOST, MODE_READ, HOST_SLOT_TOP, 16'h0000);
        access(SIDE_CTRL, MODE_NONE, CTRL_SLOT_XFER, 16'hffff);
    endtask

    // Pushes a run of words, then drains them and pops past empty.
    task automatic test_fifo_capacity();
        logic [15:0] ctl;
        in_gap_pct = 5;
        out_stall_pct = 5;
        ctl = '0;
        ctl[TC_EN] = 1'b1;
        ctl[TC_CLEAR] = 1'b1;
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_XFER, ctl);
        repeat (50)
            access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_DATA, 16'($urandom));
        repeat (52)
            access(SIDE_CTRL, MODE_READ, CTRL_SLOT_DATA, 16'h0000);
        drain_results();
    endtask

    // The result side holds off while beats keep coming, so the block backs up.
    task automatic test_backpressure();
        in_gap_pct = 0;
        out_stall_pct = 0;
        out_hold_cycles = 300;
        repeat (40)
            access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_MISC1, 16'($urandom));
        drain_results();
    endtask

    function automatic in_item_t random_access();
        in_item_t a;
        int r;
        a.side = 1'($urandom_range(1));
        r = $urandom_range(99);
        a.mode = (r < 45) ? MODE_READ : (r < 90) ? MODE_WRITE : (r < 97) ? MODE_EVENT : MODE_NONE;
        a.reg_index = ($urandom_range(3) == 0) ? CTRL_SLOT_DATA : 4'($urandom_range(15));
        r = $urandom_range(9);
        a.write_data = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom);
        // Keep most control writes from wiping the FIFO.
        if (a.side == SIDE_CTRL && a.reg_index == CTRL_SLOT_XFER && $urandom_range(3) != 0)
            a.write_data[TC_CLEAR] = 1'b0;
        return a;
    endfunction

    task automatic command_exchange();
        for (int k = 0; k < 4; k++)
            access(SIDE_HOST, MODE_WRITE, HOST_SLOT_CR1 + 4'(k), 16'($urandom));
        for (int k = 0; k < 4; k++)
            access(SIDE_CTRL, MODE_READ, CTRL_SLOT_CMD0 + 4'(k), 16'h0000);
        for (int k = 0; k < 4; k++)
            access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_CMD0 + 4'(k), 16'($urandom));
        for (int k = 0; k < 4; k++)
            access(SIDE_HOST, MODE_READ, HOST_SLOT_CR1 + 4'(k), 16'h0000);
    endtask

    task automatic transfer_burst();
        logic [15:0] ctl;
        int words;
        words = $urandom_range(8, 1);
        ctl = '0;
        ctl[TC_DIR] = 1'($urandom_range(1));
        ctl[TC_EN] = 1'($urandom_range(1));
        ctl[TC_CLEAR] = ($urandom_range(2) == 0);
        access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_XFER, ctl);
        if (ctl[TC_DIR])
        begin
            repeat (words)
                access(SIDE_HOST, MODE_WRITE, HOST_SLOT_DATA, 16'($urandom));
            repeat (words)
                access(SIDE_CTRL, MODE_READ, CTRL_SLOT_DATA, 16'h0000);
        end
        else
        begin
            repeat (words)
                access(SIDE_CTRL, MODE_WRITE, CTRL_SLOT_DATA, 16'($urandom));
            repeat (words)
                access(SIDE_HOST, MODE_READ, HOST_SLOT_DATA, 16'h0000);
        end
    endtask

    task automatic test_random_mix(int beats, int gap_pct, int stall_pct);
        int start;
        int r;
        start = beats_sent;
        in_gap_pct = gap_pct;
        out_stall_pct = stall_pct;
        while (beats_sent - start < beats)
        begin
            r = $urandom_range(99);
            if (r < 15)
                command_exchange();
            else if (r < 45)
                transfer_burst();
            else
                repeat ($urandom_range(6, 1))
                    send_access(random_access());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        error_count = 0;
        beats_sent = 0;
        in_gap_pct = 20;
        out_stall_pct = 20;
        out_hold_cycles = 0;
        out_stall_left = 0;
        clear_register_file();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_interrupt_lines();
        test_command_response();
        test_fifo_corners();
        test_unmapped_slots();
        drain_results();
        test_fifo_capacity();
        test_backpressure();
        test_random_mix(120, 0, 0);
        test_random_mix(125, 30, 30);
        test_random_mix(125, 60, 50);

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
